>>> hdl/adfp_pkg.sv
// Shared constants and helpers for the ASCII decimal to fixed-point parser.
// Used by the parser top level and by its port checker; depends on nothing.

package adfp_pkg;

	// Width of one parsed value.
	localparam int unsigned VALUE_W = 48;

	// Width of the fraction digit counter.
	localparam int unsigned COUNT_W = 4;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_DOT   = 8'd46;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	// Clamp limits of the value field.
	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Power of ten, evaluated at elaboration to build the weight table.
	function automatic longint unsigned pow10(input int unsigned k);
		longint unsigned p;
		p = 64'd1;
		for (int unsigned i = 0; i < k; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

>>> hdl/ascii_decimal_to_fixed_parser.sv
// Top level of the ASCII decimal to fixed-point parser.
// Depends on adfp_pkg for character codes, clamp limits and powers of ten.

// The parser takes one text byte per item and produces one signed fixed-point
// value with FRACTION_BITS fraction bits for every space, and for a NUL that
// ends a non-empty token (that value is flagged last). It accepts one byte
// every clock cycle unless in_stall holds the input; a result passes from the
// input register to the result register, where it is offered on out_valid.
// The clock rate is set by the
// accumulator update: a multiply by ten as a shift-add, or a digit times a
// power-of-ten weight, followed by the 48-bit clamp. While a result waits
// under stall, bytes that produce no result keep flowing; only a byte that
// would produce another result holds the input.

module ascii_decimal_to_fixed_parser #(
	parameter int unsigned MAX_FRACTION_DIGITS = 8,
	parameter int unsigned FRACTION_BITS       = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           char_code,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [adfp_pkg::VALUE_W-1:0]  value,
	output logic                                 last,
	output logic                                 saturated
);

	localparam int unsigned VW     = adfp_pkg::VALUE_W;
	localparam int unsigned CW     = adfp_pkg::COUNT_W;
	localparam int unsigned SUM_W  = VW + 5;
	localparam int unsigned WGT_W  = FRACTION_BITS - 2;
	localparam int unsigned DIG_W  = 9;
	localparam int unsigned PROD_W = DIG_W + WGT_W + 1;
	localparam int unsigned N_WGT  = 2 ** CW;

	// Input register.
	logic                 valid_s1;
	logic [7:0]           char_s1;

	// Token state.
	logic signed [VW-1:0] acc_q;
	logic                 neg_q;
	logic                 frac_q;
	logic [CW-1:0]        cnt_q;
	logic                 started_q;
	logic                 ovf_q;

	// Result register.
	logic                 out_valid_q;
	logic signed [VW-1:0] value_q;
	logic                 last_q;
	logic                 sat_q;

	// Combinational signals.
	logic [WGT_W-1:0]        frac_weight [N_WGT];
	logic                    emits_s1;
	logic                    out_free;
	logic                    fire_s1;
	logic signed [DIG_W-1:0] digit;
	logic [CW-1:0]           cnt_inc;
	logic signed [SUM_W-1:0] acc_ext;
	logic signed [SUM_W-1:0] int_sum;
	logic signed [PROD_W-1:0] frac_prod;
	logic signed [SUM_W-1:0] frac_sum;
	logic signed [SUM_W-1:0] sel_sum;
	logic signed [VW-1:0]    clamp_val;
	logic                    clamp_hit;
	logic signed [VW-1:0]    emit_val;
	logic                    emit_sat;

	// Weight of fraction digit k: 2^F / 10^k rounded to nearest, halves up.
	assign frac_weight[0] = '0;
	for (genvar k = 1; k < N_WGT; k++) begin : g_wgt
		localparam longint unsigned P = adfp_pkg::pow10(k);
		localparam longint unsigned W = ((64'd1 << FRACTION_BITS) + P / 64'd2) / P;
		assign frac_weight[k] = WGT_W'(W);
	end

	// Flow control: a byte leaves the input register unless it would produce a
	// result while the result register is still held.
	assign emits_s1 = (char_s1 == adfp_pkg::CHAR_SPACE) ||
		((char_s1 == adfp_pkg::CHAR_NUL) && started_q);
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (out_free || !emits_s1);
	assign in_stall = valid_s1 && !fire_s1;

	// Digit value, which is negative for bytes below the digit zero.
	assign digit   = $signed({1'b0, char_s1}) - $signed({1'b0, adfp_pkg::CHAR_ZERO});
	assign cnt_inc = cnt_q + CW'(1);
	assign acc_ext = SUM_W'(acc_q);

	// Integer digit: accumulator times ten plus the digit scaled to one unit.
	assign int_sum = (acc_ext <<< 3) + (acc_ext <<< 1) +
		(SUM_W'(digit) <<< FRACTION_BITS);

	// Fraction digit: the digit times the weight of its position.
	assign frac_prod = PROD_W'(digit) * PROD_W'($signed({1'b0, frac_weight[cnt_inc]}));
	assign frac_sum  = acc_ext + SUM_W'(frac_prod);
	assign sel_sum   = frac_q ? frac_sum : int_sum;

	// Clamp the new partial sum to the value range.
	always_comb begin
		clamp_hit = 1'b1;
		priority if (sel_sum > SUM_W'(adfp_pkg::VAL_MAX)) begin
			clamp_val = adfp_pkg::VAL_MAX;
		end else if (sel_sum < SUM_W'(adfp_pkg::VAL_MIN)) begin
			clamp_val = adfp_pkg::VAL_MIN;
		end else begin
			clamp_val = VW'(sel_sum);
			clamp_hit = 1'b0;
		end
	end

	// Signed value of the finished token; the most negative value saturates.
	always_comb begin
		emit_sat = ovf_q;
		if (neg_q) begin
			if (acc_q == adfp_pkg::VAL_MIN) begin
				emit_val = adfp_pkg::VAL_MAX;
				emit_sat = 1'b1;
			end else begin
				emit_val = -acc_q;
			end
		end else begin
			emit_val = acc_q;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	// Token state update, one byte per cycle while the input register is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			neg_q     <= 1'b0;
			frac_q    <= 1'b0;
			cnt_q     <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (fire_s1) begin
			priority if ((char_s1 == adfp_pkg::CHAR_NUL) ||
					(char_s1 == adfp_pkg::CHAR_SPACE)) begin
				acc_q     <= '0;
				neg_q     <= 1'b0;
				frac_q    <= 1'b0;
				cnt_q     <= '0;
				started_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else if (!started_q && (char_s1 == adfp_pkg::CHAR_MINUS)) begin
				neg_q     <= 1'b1;
				started_q <= 1'b1;
			end else if (!frac_q) begin
				started_q <= 1'b1;
				if (char_s1 == adfp_pkg::CHAR_DOT) begin
					frac_q <= 1'b1;
				end else begin
					acc_q <= clamp_val;
					ovf_q <= ovf_q | clamp_hit;
				end
			end else begin
				started_q <= 1'b1;
				if (cnt_q < CW'(MAX_FRACTION_DIGITS)) begin
					cnt_q <= cnt_inc;
					acc_q <= clamp_val;
					ovf_q <= ovf_q | clamp_hit;
				end
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emits_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire_s1 && emits_s1) begin
			value_q <= emit_val;
			last_q  <= (char_s1 == adfp_pkg::CHAR_NUL);
			sat_q   <= emit_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign last      = last_q;
	assign saturated = sat_q;

endmodule

>>> hdl/adfp_checker.sv
// Port-level checks for the ASCII decimal to fixed-point parser.
// Depends on adfp_pkg; bound to ascii_decimal_to_fixed_parser at the end.

module adfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] char_code,
	input logic       out_valid,
	input logic       out_stall
);

	// A result held under stall stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// The input is only held back by a result that cannot leave.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// An accepted space yields a result once the output can move.
	a_space_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (char_code == adfp_pkg::CHAR_SPACE))
		##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("space accepted but no result followed");

	// No result is offered just as reset is released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered straight after reset");

endmodule

bind ascii_decimal_to_fixed_parser adfp_checker u_adfp_checker (.*);
